[src/ffha_pkg.sv]
`timescale 1ns / 1ps

package ffha_pkg;

   // heap geometry
   localparam int HEAP_BYTES = 65536;
   localparam int ADDR_SPACE = 65536;
   localparam int HEAP_WORDS = HEAP_BYTES / 4;
   localparam int ROW_BITS   = $clog2(HEAP_WORDS);
   localparam int ADDR_BITS  = 16;
   localparam int WORD_BITS  = 32;

   // field widths
   localparam int REQ_BITS   = 17;
   localparam int SIZE_BITS  = REQ_BITS + 1;
   localparam int LIMIT_BITS = 17;

   // block layout
   localparam int HEADER_BYTES = 8;
   localparam int FLAG_OFFSET  = 4;
   localparam int USED_FLAG    = 1;
   localparam int MIN_PAYLOAD  = 4;
   localparam int ALIGN_MASK   = 3;
   localparam int SPLIT_MARGIN = HEADER_BYTES + MIN_PAYLOAD;

   // list walk bound
   localparam int VISIT_CAP  = HEAP_BYTES / 12 + 1;
   localparam int VISIT_BITS = $clog2(VISIT_CAP + 1);

   // break limit
   localparam logic [LIMIT_BITS-1:0] LIMIT_CAP =
      LIMIT_BITS'((HEAP_BYTES < ADDR_SPACE) ? HEAP_BYTES : ADDR_SPACE);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 17'd65536;

   // register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEAP_LIMIT = '0;

   typedef enum logic [1:0] {
      STATUS_DONE         = 2'd0,
      STATUS_ZERO_SIZE    = 2'd1,
      STATUS_NO_MEMORY    = 2'd2,
      STATUS_NULL_RELEASE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_RD_LINK,
      ST_EVAL,
      ST_SPLIT_SIZE,
      ST_SPLIT_FLAG,
      ST_SPLIT_LINK,
      ST_TRIM,
      ST_RELINK,
      ST_MARK_USED,
      ST_BRK_CHECK,
      ST_BRK_FLAG,
      ST_REL_FLAG,
      ST_REL_LINK
   } state_type;

   typedef enum logic [3:0] {
      ADDR_CUR_M8,
      ADDR_CUR,
      ADDR_CUR_M4,
      ADDR_TP_M8,
      ADDR_TP_M4,
      ADDR_TP,
      ADDR_PREV,
      ADDR_BRK,
      ADDR_BRK_P4,
      ADDR_PTR_M4,
      ADDR_PTR
   } addr_sel_type;

   typedef enum logic [2:0] {
      WD_REM,
      WD_ZERO,
      WD_NXT,
      WD_SIZE,
      WD_REPL,
      WD_ONE,
      WD_HEAD
   } wdata_sel_type;

   typedef enum logic [1:0] {
      HEAD_HOLD,
      HEAD_REPL,
      HEAD_PTR
   } head_sel_type;

   typedef enum logic [2:0] {
      RSP_OK_CUR,
      RSP_OK_BRK,
      RSP_ZERO,
      RSP_OOM,
      RSP_NULL,
      RSP_RELEASED
   } rsp_kind_type;

   typedef struct packed {
      logic          load_req;
      logic          mem_rd;
      logic          mem_wr;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          cap_size;
      logic          cap_link;
      logic          advance;
      head_sel_type  head_sel;
      logic          brk_grow;
      logic          rsp_en;
      rsp_kind_type  rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic mode;
      logic size_zero;
      logic ptr_zero;
      logic walk_end;
      logic fits;
      logic split;
      logic prev_zero;
      logic oom;
   } dp_status_type;

endpackage

[src/ffha_csr.sv]
`timescale 1ns / 1ps

module ffha_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ffha_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ffha_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ffha_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output logic [ffha_pkg::LIMIT_BITS-1:0]      heap_limit
);
   import ffha_pkg::*;

   logic [LIMIT_BITS-1:0]   heap_limit_ff;
   logic [LIMIT_BITS-1:0]   heap_limit_in;
   logic [CSR_IDX_BITS-1:0] reg_idx;
   logic                    wr_hit;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_HEAP_LIMIT);
   assign pready  = 1'b1;

   assign heap_limit_in = wr_hit ? pwdata[LIMIT_BITS-1:0] : heap_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= LIMIT_RESET;
      end else begin
         heap_limit_ff <= heap_limit_in;
      end
   end

   assign prdata = (reg_idx == REG_HEAP_LIMIT) ? CSR_DATA_BITS'(heap_limit_ff) : '0;
   assign heap_limit = heap_limit_ff;

endmodule

[src/ffha_controller.sv]
`timescale 1ns / 1ps

module ffha_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ffha_pkg::dp_status_type status,
   output logic                    busy,
   output ffha_pkg::dp_cmd_type    cmd
);
   import ffha_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.mode) begin
               state_in = status.ptr_zero ? ST_IDLE : ST_REL_FLAG;
            end else begin
               state_in = status.size_zero ? ST_IDLE : ST_WALK;
            end
         end
         ST_WALK:       state_in = status.walk_end ? ST_BRK_CHECK : ST_RD_LINK;
         ST_RD_LINK:    state_in = ST_EVAL;
         ST_EVAL: begin
            if (status.fits) begin
               state_in = status.split ? ST_SPLIT_SIZE : ST_RELINK;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_SPLIT_SIZE: state_in = ST_SPLIT_FLAG;
         ST_SPLIT_FLAG: state_in = ST_SPLIT_LINK;
         ST_SPLIT_LINK: state_in = ST_TRIM;
         ST_TRIM:       state_in = ST_RELINK;
         ST_RELINK:     state_in = ST_MARK_USED;
         ST_MARK_USED:  state_in = ST_IDLE;
         ST_BRK_CHECK:  state_in = status.oom ? ST_IDLE : ST_BRK_FLAG;
         ST_BRK_FLAG:   state_in = ST_IDLE;
         ST_REL_FLAG:   state_in = ST_REL_LINK;
         ST_REL_LINK:   state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      cmd           = '0;
      cmd.addr_sel  = ADDR_CUR;
      cmd.wdata_sel = WD_ZERO;
      cmd.head_sel  = HEAD_HOLD;
      cmd.rsp_kind  = RSP_RELEASED;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_req = start;
         end
         ST_DISPATCH: begin
            if (status.mode && status.ptr_zero) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = RSP_NULL;
            end else if (!status.mode && status.size_zero) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = RSP_ZERO;
            end
         end
         ST_WALK: begin
            if (!status.walk_end) begin
               cmd.mem_rd   = 1'b1;
               cmd.addr_sel = ADDR_CUR_M8;
            end
         end
         ST_RD_LINK: begin
            cmd.cap_size = 1'b1;
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_CUR;
         end
         ST_EVAL: begin
            cmd.cap_link = 1'b1;
            cmd.advance  = !status.fits;
         end
         ST_SPLIT_SIZE: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_TP_M8;
            cmd.wdata_sel = WD_REM;
         end
         ST_SPLIT_FLAG: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_TP_M4;
            cmd.wdata_sel = WD_ZERO;
         end
         ST_SPLIT_LINK: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_TP;
            cmd.wdata_sel = WD_NXT;
         end
         ST_TRIM: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_CUR_M8;
            cmd.wdata_sel = WD_SIZE;
         end
         ST_RELINK: begin
            if (status.prev_zero) begin
               cmd.head_sel = HEAD_REPL;
            end else begin
               cmd.mem_wr    = 1'b1;
               cmd.addr_sel  = ADDR_PREV;
               cmd.wdata_sel = WD_REPL;
            end
         end
         ST_MARK_USED: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_CUR_M4;
            cmd.wdata_sel = WD_ONE;
            cmd.rsp_en    = 1'b1;
            cmd.rsp_kind  = RSP_OK_CUR;
         end
         ST_BRK_CHECK: begin
            if (status.oom) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = RSP_OOM;
            end else begin
               cmd.mem_wr    = 1'b1;
               cmd.addr_sel  = ADDR_BRK;
               cmd.wdata_sel = WD_SIZE;
            end
         end
         ST_BRK_FLAG: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_BRK_P4;
            cmd.wdata_sel = WD_ONE;
            cmd.brk_grow  = 1'b1;
            cmd.rsp_en    = 1'b1;
            cmd.rsp_kind  = RSP_OK_BRK;
         end
         ST_REL_FLAG: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_PTR_M4;
            cmd.wdata_sel = WD_ZERO;
         end
         ST_REL_LINK: begin
            cmd.mem_wr    = 1'b1;
            cmd.addr_sel  = ADDR_PTR;
            cmd.wdata_sel = WD_HEAD;
            cmd.head_sel  = HEAD_PTR;
            cmd.rsp_en    = 1'b1;
            cmd.rsp_kind  = RSP_RELEASED;
         end
         default: begin
            cmd.load_req = 1'b0;
         end
      endcase
   end

endmodule

[src/ffha_datapath.sv]
`timescale 1ns / 1ps

module ffha_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ffha_pkg::dp_cmd_type              cmd,
   input  logic                              req_mode,
   input  logic [ffha_pkg::REQ_BITS-1:0]     req_request_size,
   input  logic [ffha_pkg::ADDR_BITS-1:0]    req_block_pointer,
   input  logic [ffha_pkg::LIMIT_BITS-1:0]   heap_limit,
   output ffha_pkg::dp_status_type           status,
   output logic                              rsp_valid,
   output logic [ffha_pkg::ADDR_BITS-1:0]    rsp_payload_address,
   output logic [1:0]                        rsp_status
);
   import ffha_pkg::*;

   // item registers
   logic                    mode_ff;
   logic                    size_zero_ff;
   logic [SIZE_BITS-1:0]    size_ff;
   logic [ADDR_BITS-1:0]    ptr_ff;
   // walk registers
   logic [ADDR_BITS-1:0]    cur_ff;
   logic [ADDR_BITS-1:0]    prev_ff;
   logic [VISIT_BITS-1:0]   visits_ff;
   logic [WORD_BITS-1:0]    csz_ff;
   logic [ADDR_BITS-1:0]    nxt_ff;
   logic [ADDR_BITS-1:0]    repl_ff;
   // heap state
   logic [ADDR_BITS-1:0]    head_ff;
   logic [LIMIT_BITS-1:0]   brk_ff;
   // result
   logic                    rsp_valid_ff;
   logic [ADDR_BITS-1:0]    rsp_addr_ff;
   status_type              rsp_status_ff;
   logic [ADDR_BITS-1:0]    rsp_addr_in;
   status_type              rsp_status_in;

   // heap memory: four byte lanes so a word at any byte offset is one access
   logic [7:0]              heap_mem [4][HEAP_WORDS];
   logic [7:0]              lane_q_ff [4];
   logic [1:0]              rd_off_ff;
   logic [ROW_BITS-1:0]     lane_row [4];
   logic [7:0]              lane_wbyte [4];
   logic [ADDR_BITS-1:0]    mem_addr;
   logic [WORD_BITS-1:0]    mem_wdata;
   logic [WORD_BITS-1:0]    mem_rdata;

   // derived values
   logic [REQ_BITS-1:0]     req_min;
   logic [SIZE_BITS-1:0]    req_round;
   logic [ADDR_BITS-1:0]    tp;
   logic [SIZE_BITS-1:0]    need;
   logic [LIMIT_BITS-1:0]   lim;
   logic                    split;

   assign req_min   = (req_request_size < REQ_BITS'(MIN_PAYLOAD)) ?
                      REQ_BITS'(MIN_PAYLOAD) : req_request_size;
   assign req_round = ({1'b0, req_min} + SIZE_BITS'(ALIGN_MASK)) & ~SIZE_BITS'(ALIGN_MASK);

   assign tp    = cur_ff + size_ff[ADDR_BITS-1:0] + ADDR_BITS'(HEADER_BYTES);
   assign need  = size_ff + SIZE_BITS'(HEADER_BYTES);
   assign lim   = (heap_limit < LIMIT_CAP) ? heap_limit : LIMIT_CAP;
   assign split = ({1'b0, csz_ff} >= ((WORD_BITS + 1)'(size_ff) + (WORD_BITS + 1)'(SPLIT_MARGIN)));

   always_comb begin
      status.mode      = mode_ff;
      status.size_zero = size_zero_ff;
      status.ptr_zero  = (ptr_ff == '0);
      status.walk_end  = (cur_ff == '0) || (visits_ff >= VISIT_BITS'(VISIT_CAP));
      status.fits      = (csz_ff >= WORD_BITS'(size_ff));
      status.split     = split;
      status.prev_zero = (prev_ff == '0);
      status.oom       = (brk_ff > lim) || (need > SIZE_BITS'(lim - brk_ff));
   end

   // address and write data selection
   always_comb begin
      case (cmd.addr_sel)
         ADDR_CUR_M8: mem_addr = cur_ff - ADDR_BITS'(HEADER_BYTES);
         ADDR_CUR:    mem_addr = cur_ff;
         ADDR_CUR_M4: mem_addr = cur_ff - ADDR_BITS'(FLAG_OFFSET);
         ADDR_TP_M8:  mem_addr = tp - ADDR_BITS'(HEADER_BYTES);
         ADDR_TP_M4:  mem_addr = tp - ADDR_BITS'(FLAG_OFFSET);
         ADDR_TP:     mem_addr = tp;
         ADDR_PREV:   mem_addr = prev_ff;
         ADDR_BRK:    mem_addr = brk_ff[ADDR_BITS-1:0];
         ADDR_BRK_P4: mem_addr = brk_ff[ADDR_BITS-1:0] + ADDR_BITS'(FLAG_OFFSET);
         ADDR_PTR_M4: mem_addr = ptr_ff - ADDR_BITS'(FLAG_OFFSET);
         ADDR_PTR:    mem_addr = ptr_ff;
         default:     mem_addr = cur_ff;
      endcase
   end

   always_comb begin
      case (cmd.wdata_sel)
         WD_REM:  mem_wdata = csz_ff - WORD_BITS'(size_ff) - WORD_BITS'(HEADER_BYTES);
         WD_ZERO: mem_wdata = '0;
         WD_NXT:  mem_wdata = WORD_BITS'(nxt_ff);
         WD_SIZE: mem_wdata = WORD_BITS'(size_ff);
         WD_REPL: mem_wdata = WORD_BITS'(repl_ff);
         WD_ONE:  mem_wdata = WORD_BITS'(USED_FLAG);
         WD_HEAD: mem_wdata = WORD_BITS'(head_ff);
         default: mem_wdata = '0;
      endcase
   end

   // lane k holds word byte (k - addr) mod 4, at row of addr + that byte
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic [1:0]           bsel;
         logic [ADDR_BITS-1:0] baddr;
         bsel          = 2'(k) - mem_addr[1:0];
         baddr         = mem_addr + ADDR_BITS'(bsel);
         lane_row[k]   = baddr[ROW_BITS+1:2];
         lane_wbyte[k] = mem_wdata[{bsel, 3'b000} +: 8];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (cmd.mem_wr) heap_mem[k][lane_row[k]] <= lane_wbyte[k];
         if (cmd.mem_rd) lane_q_ff[k] <= heap_mem[k][lane_row[k]];
      end
      if (cmd.mem_rd) rd_off_ff <= mem_addr[1:0];
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         mem_rdata[8*j +: 8] = lane_q_ff[rd_off_ff + 2'(j)];
      end
   end

   // item and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff      <= req_mode;
         size_zero_ff <= (req_request_size == '0);
         size_ff      <= req_round;
         ptr_ff       <= req_block_pointer;
         cur_ff       <= head_ff;
         prev_ff      <= '0;
         visits_ff    <= '0;
      end else if (cmd.advance) begin
         prev_ff   <= cur_ff;
         cur_ff    <= mem_rdata[ADDR_BITS-1:0];
         visits_ff <= visits_ff + 1'b1;
      end
      if (cmd.cap_size) csz_ff <= mem_rdata;
      if (cmd.cap_link) begin
         nxt_ff  <= mem_rdata[ADDR_BITS-1:0];
         repl_ff <= split ? tp : mem_rdata[ADDR_BITS-1:0];
      end
   end

   // free list head and break
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         brk_ff  <= '0;
      end else begin
         case (cmd.head_sel)
            HEAD_REPL: head_ff <= repl_ff;
            HEAD_PTR:  head_ff <= ptr_ff;
            default:   head_ff <= head_ff;
         endcase
         if (cmd.brk_grow) brk_ff <= brk_ff + need[LIMIT_BITS-1:0];
      end
   end

   // result register
   always_comb begin
      case (cmd.rsp_kind)
         RSP_OK_CUR: begin
            rsp_addr_in   = cur_ff;
            rsp_status_in = STATUS_DONE;
         end
         RSP_OK_BRK: begin
            rsp_addr_in   = brk_ff[ADDR_BITS-1:0] + ADDR_BITS'(HEADER_BYTES);
            rsp_status_in = STATUS_DONE;
         end
         RSP_ZERO: begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_ZERO_SIZE;
         end
         RSP_OOM: begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_NO_MEMORY;
         end
         RSP_NULL: begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_NULL_RELEASE;
         end
         default: begin
            rsp_addr_in   = '0;
            rsp_status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_en;
      end
      if (cmd.rsp_en) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

[src/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// an allocation walks the free list and takes the first block that fits, splitting it when
// the surplus is large enough, or else grows the break; a release writes flag and link
// the result strobe is high one cycle, right after the last busy cycle; each free-list
// entry costs a size read and a link read on the single heap memory port
// throughput: one transaction at a time; the next start is taken during the strobe cycle
// reset: synchronous active high; empties the free list, zeroes the break, limit to 65536

module first_fit_heap_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   // request transaction
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic [ffha_pkg::REQ_BITS-1:0]        req_request_size,
   input  logic [ffha_pkg::ADDR_BITS-1:0]       req_block_pointer,
   // result transaction, cannot be stalled
   output logic                                 rsp_valid,
   output logic [ffha_pkg::ADDR_BITS-1:0]       rsp_payload_address,
   output logic [1:0]                           rsp_status,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ffha_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ffha_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ffha_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import ffha_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type            cmd;
   dp_status_type         status;
   logic [LIMIT_BITS-1:0] heap_limit;

   // heap_limit register at byte address 0
   ffha_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .heap_limit (heap_limit)
   );

   // sequencer: dispatch, list walk, split writes, relink, break growth, release
   ffha_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // heap memory, walk pointers, free list head, break and result register
   ffha_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_block_pointer   (req_block_pointer),
      .heap_limit          (heap_limit),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status)
   );

endmodule

[src/ffha_checker.sv]
`timescale 1ns / 1ps

module ffha_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [ffha_pkg::ADDR_BITS-1:0]    rsp_payload_address,
   input logic [1:0]                        rsp_status
);
   import ffha_pkg::*;

   // idle and quiet right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or strobe right after reset");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accepted transaction");

   // strobes never stand in back-to-back cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in flight");

   // only a completed transaction carries an address
   a_addr_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_DONE)) |-> (rsp_payload_address == '0))
      else $error("nonzero address on a failed or ignored transaction");

endmodule

bind first_fit_heap_allocator ffha_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_payload_address (rsp_payload_address),
   .rsp_status          (rsp_status)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import ffha_pkg::*;

   // run shape
   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int DRAIN_LIMIT   = 60000;
   localparam int SETTLE_CYCLES = 20;
   localparam int SEGMENT_ITEMS = 100;
   localparam int SEGMENT_COUNT = 8;
   localparam int MAX_REPORTS   = 10;

   // transaction codes
   localparam bit MODE_ALLOC   = 1'b0;
   localparam bit MODE_RELEASE = 1'b1;

   // field extremes
   localparam logic [REQ_BITS-1:0]   REQ_MAX        = '1;
   localparam logic [LIMIT_BITS-1:0] LIMIT_MIN      = 17'd16;
   localparam logic [LIMIT_BITS-1:0] LIMIT_ALL_ONES = '1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      status_type           status;
   } grant_type;

   // heap shadow plus queue of outstanding grants
   class heap_scoreboard;
      bit [WORD_BITS-1:0]  heap_mem [HEAP_WORDS];
      bit [ADDR_BITS-1:0]  free_head;
      int unsigned         break_ofs;
      bit [LIMIT_BITS-1:0] heap_limit;
      grant_type           pending_q[$];
      int unsigned         mismatches;

      function new();
         free_head  = '0;
         break_ofs  = 0;
         heap_limit = LIMIT_RESET;
         mismatches = 0;
      endfunction

      // every block lives on a word boundary
      function bit [WORD_BITS-1:0] peek(bit [ADDR_BITS-1:0] a);
         return heap_mem[a[ADDR_BITS-1:2]];
      endfunction

      function void poke(bit [ADDR_BITS-1:0] a, bit [WORD_BITS-1:0] v);
         heap_mem[a[ADDR_BITS-1:2]] = v;
      endfunction

      function grant_type allocate(int unsigned req);
         bit [ADDR_BITS-1:0] prev, cur, nxt, tail, repl;
         int unsigned size, csz, lim, need, visits;
         grant_type g;
         prev     = '0;
         cur      = free_head;
         visits   = 0;
         g.addr   = '0;
         g.status = STATUS_NO_MEMORY;
         if (req == 0) begin
            g.status = STATUS_ZERO_SIZE;
            return g;
         end
         size = (req < MIN_PAYLOAD) ? MIN_PAYLOAD : req;
         size = (size + ALIGN_MASK) & ~ALIGN_MASK;
         // first fit, a self-linked list gives up at the visit cap
         while (cur != 0 && visits < VISIT_CAP) begin
            csz = peek(ADDR_BITS'(cur - HEADER_BYTES));
            nxt = ADDR_BITS'(peek(cur));
            if (csz >= size) begin
               if (csz >= size + SPLIT_MARGIN) begin
                  tail = ADDR_BITS'(cur + size + HEADER_BYTES);
                  poke(ADDR_BITS'(tail - HEADER_BYTES), csz - size - HEADER_BYTES);
                  poke(ADDR_BITS'(tail - FLAG_OFFSET), '0);
                  poke(tail, WORD_BITS'(nxt));
                  poke(ADDR_BITS'(cur - HEADER_BYTES), size);
                  repl = tail;
               end else begin
                  repl = nxt;
               end
               if (prev != 0) poke(prev, WORD_BITS'(repl));
               else free_head = repl;
               poke(ADDR_BITS'(cur - FLAG_OFFSET), USED_FLAG);
               g.addr   = cur;
               g.status = STATUS_DONE;
               return g;
            end
            prev = cur;
            cur  = nxt;
            visits++;
         end
         // grow the break, a limit below the break refuses everything
         lim  = 32'((heap_limit > LIMIT_CAP) ? LIMIT_CAP : heap_limit);
         need = HEADER_BYTES + size;
         if (break_ofs > lim || need > lim - break_ofs) return g;
         poke(ADDR_BITS'(break_ofs), size);
         poke(ADDR_BITS'(break_ofs + FLAG_OFFSET), USED_FLAG);
         g.addr    = ADDR_BITS'(break_ofs + HEADER_BYTES);
         g.status  = STATUS_DONE;
         break_ofs = break_ofs + need;
         return g;
      endfunction

      function grant_type release_block(bit [ADDR_BITS-1:0] ptr);
         grant_type g;
         g.addr = '0;
         if (ptr == 0) begin
            g.status = STATUS_NULL_RELEASE;
            return g;
         end
         poke(ADDR_BITS'(ptr - FLAG_OFFSET), '0);
         poke(ptr, WORD_BITS'(free_head));
         free_head = ptr;
         g.status  = STATUS_DONE;
         return g;
      endfunction

      function grant_type note_item(bit mode, int unsigned req, bit [ADDR_BITS-1:0] ptr);
         grant_type g;
         g = (mode == MODE_ALLOC) ? allocate(req) : release_block(ptr);
         pending_q.push_back(g);
         return g;
      endfunction

      function void flag_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("%s", msg);
      endfunction

      function void check_result(logic [ADDR_BITS-1:0] addr, logic [1:0] status);
         grant_type want;
         if (pending_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: addr %0d status %0d", addr, status));
            return;
         end
         want = pending_q.pop_front();
         if (addr !== want.addr || status !== want.status)
            flag_mismatch($sformatf(
               "result mismatch: expected addr %0d status %s, got addr %0d status %0d",
               want.addr, want.status.name(), addr, status));
      endfunction

      function void set_limit(bit [CSR_DATA_BITS-1:0] data);
         heap_limit = data[LIMIT_BITS-1:0];
      endfunction

      function void check_readback(logic [CSR_DATA_BITS-1:0] got);
         if (got !== CSR_DATA_BITS'(heap_limit))
            flag_mismatch($sformatf("heap_limit readback: expected %0d, got %0d",
                                    heap_limit, got));
      endfunction

      function void close_out();
         if (pending_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_q.size()));
      endfunction
   endclass

   // dut-facing signals, inputs all known from time zero
   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     start             = 1'b0;
   logic                     busy;
   logic                     req_mode          = MODE_ALLOC;
   logic [REQ_BITS-1:0]      req_request_size  = '0;
   logic [ADDR_BITS-1:0]     req_block_pointer = '0;
   logic                     rsp_valid;
   logic [ADDR_BITS-1:0]     rsp_payload_address;
   logic [1:0]               rsp_status;
   logic                     psel              = 1'b0;
   logic                     penable           = 1'b0;
   logic                     pwrite            = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr             = '0;
   logic [CSR_DATA_BITS-1:0] pwdata            = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   heap_scoreboard     sb = new();
   bit [ADDR_BITS-1:0] owned_q[$];   // payloads granted and not yet handed back
   int unsigned        idle_pct = 29;
   int unsigned        cycle_count = 0;

   first_fit_heap_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_block_pointer   (req_block_pointer),
      .rsp_valid           (rsp_valid),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #(CLK_HALF) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** first_fit_heap_allocator: FAILED **");
         $finish;
      end
   end

   // result side never stalls, every strobe is a transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_payload_address, rsp_status);
   end

   // one request transaction; start stays high when the next call follows at once
   task automatic send_item(bit mode, bit [REQ_BITS-1:0] req, bit [ADDR_BITS-1:0] ptr);
      grant_type g;
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      start             <= 1'b1;
      req_mode          <= mode;
      req_request_size  <= req;
      req_block_pointer <= ptr;
      do @(posedge clock); while (busy);
      g = sb.note_item(mode, req, ptr);
      if (mode == MODE_ALLOC && g.status == STATUS_DONE) owned_q.push_back(g.addr);
   endtask

   // the pointer field is unused on allocate, so it carries noise there
   task automatic alloc_item(bit [REQ_BITS-1:0] req);
      send_item(MODE_ALLOC, req, ADDR_BITS'($urandom));
   endtask

   task automatic release_owned(int idx);
      bit [ADDR_BITS-1:0] ptr;
      ptr = owned_q[idx];
      owned_q.delete(idx);
      send_item(MODE_RELEASE, REQ_BITS'($urandom), ptr);
   endtask

   // hold off the sender until every grant has come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write then read-back, only with the block idle
   task automatic write_limit(bit [LIMIT_BITS-1:0] value);
      bit [CSR_DATA_BITS-1:0] data;
      data = $urandom();
      data[LIMIT_BITS-1:0] = value;   // upper bits are noise the block must drop
      drain();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_HEAP_LIMIT, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_limit(data);
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.check_readback(prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly well-formed alloc/free traffic, some null releases and huge requests
   task automatic random_item();
      int unsigned        pick;
      bit [REQ_BITS-1:0]  req;
      pick = $urandom_range(99);
      if (pick < 4) begin
         send_item(MODE_RELEASE, REQ_BITS'($urandom), '0);
      end else if (pick < 44 && owned_q.size() != 0) begin
         release_owned($urandom_range(owned_q.size() - 1));
      end else begin
         pick = $urandom_range(99);
         if (pick < 5) req = REQ_BITS'($urandom_range(3));
         else if (pick < 75) req = REQ_BITS'($urandom_range(64, 1));
         else if (pick < 93) req = REQ_BITS'($urandom_range(1024, 65));
         else req = REQ_BITS'($urandom);
         alloc_item(req);
      end
   endtask

   initial begin
      bit [LIMIT_BITS-1:0] limit_val;
      bit [ADDR_BITS-1:0]  loop_ptr;
      int unsigned         waited;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest limit: exactly one minimum block fits, the second does not
      write_limit(LIMIT_MIN);
      alloc_item(1);
      alloc_item(4);
      write_limit(LIMIT_RESET);

      // zero size and null release
      alloc_item(0);
      send_item(MODE_RELEASE, REQ_MAX, '0);

      // rounding up from the bottom of the range
      alloc_item(1);
      alloc_item(3);
      alloc_item(5);
      alloc_item(64);
      alloc_item(16);

      // oversized requests with nothing on the free list
      alloc_item(REQ_MAX);
      alloc_item(17'd65536);

      // free the 64 and a 4, then a 12 walks past the 4 and splits the 64
      release_owned(4);
      release_owned(1);
      alloc_item(12);

      // free the 16: an 8 takes it whole, the surplus is too small to split
      release_owned(3);
      alloc_item(8);
      alloc_item(4);      // exact fit on the small block
      alloc_item(44);     // exact fit on the split tail
      alloc_item(17'd65531);

      // random traffic in segments, each setting its limit and idle rate
      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         idle_pct = (seg < 3) ? 29 : (seg < 6) ? 86 : 0;
         case (seg)
            0:       limit_val = LIMIT_RESET;
            1:       limit_val = LIMIT_ALL_ONES;
            2:       limit_val = LIMIT_MIN;       // below the break, growth refused
            4:       limit_val = 17'd65535;
            6:       limit_val = LIMIT_MIN;
            7:       limit_val = LIMIT_RESET;
            default: limit_val = LIMIT_BITS'($urandom_range(65536, 16));
         endcase
         write_limit(limit_val);
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (seg == 1 && n == SEGMENT_ITEMS / 2) drain();
            random_item();
         end
      end

      // double release makes the list point at itself; the walk must stop at the cap
      idle_pct = 0;
      if (owned_q.size() == 0) alloc_item(4);
      if (owned_q.size() != 0) begin
         loop_ptr = owned_q[owned_q.size() - 1];
         release_owned(owned_q.size() - 1);
         send_item(MODE_RELEASE, REQ_BITS'($urandom), loop_ptr);
         alloc_item(REQ_MAX);
         alloc_item(4);
         alloc_item(REQ_MAX);
      end

      // wind down
      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (sb.pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("** first_fit_heap_allocator: PASSED **");
      end else begin
         $display("** first_fit_heap_allocator: FAILED **");
      end
      $finish;
   end

endmodule
